/* src/pptu_pkg.sv */
// Package for the paddle pot pulse timer: request kinds, register indexes,
// sequence phases and the widths that follow from the sample range.
// No dependencies.
package pptu_pkg;

   // Full-scale reading; a reading r gives a raw delay of (SAMPLE_RANGE - r) / 4.
   localparam int SAMPLE_RANGE = 1024;

   // Fixed field widths
   localparam int SAMPLE_W = 10;    // brake / throttle reading
   localparam int DELAY_W  = 8;     // stored and latched delays, clamp registers
   localparam int COUNT_W  = 10;    // tick counter and discharge length
   localparam int CSR_W    = 10;    // widest configuration register
   localparam int CSR_IDX_W = 2;

   // Widths derived from the sample range
   localparam int RANGE_W = $clog2(SAMPLE_RANGE + 1);
   localparam int OPND_W  = (RANGE_W > SAMPLE_W) ? RANGE_W : SAMPLE_W;
   localparam int DIFF_W  = OPND_W + 1;
   localparam int RAW_W   = RANGE_W - 2;
   localparam int CMP_W   = (RAW_W > DELAY_W) ? RAW_W : DELAY_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register reset values
   localparam logic [COUNT_W-1:0] DISCHARGE_RST = COUNT_W'(220);
   localparam logic [DELAY_W-1:0] MIN_DELAY_RST = DELAY_W'(3);
   localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(243);

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_SYNC   = 2'd1,
      REQ_TICK   = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISCHARGE = 2'd0,
      CSR_MIN_DELAY = 2'd1,
      CSR_MAX_DELAY = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_DISCH = 4'b0010,
      PH_LEAD  = 4'b0100,
      PH_TRAIL = 4'b1000
   } phase_type;

endpackage

/* src/paddle_pot_pulse_timer_unit.sv */
// Paddle pot pulse timer: top level, the whole block in one module.
// Depends on pptu_pkg (scoped names only).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser: req_type; tdata: brake, throttle
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: pot_x_level, pot_y_level, busy_res
//  csr     | in        | csr_we (no wait)      | csr_index, csr_wdata
//
// One item per cycle: each accepted item updates the state through one level of
// logic and lands in the result register on the same edge, so its result shows
// in the next cycle. The only stored element on the item path is that result
// register; req_tready is low only while a result waits and rsp_tready is low.
// Reset (synchronous, active high) restores all state and the registers to
// their documented defaults and empties the result register.
module paddle_pot_pulse_timer_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] brake_value, [19:10] throttle_value, rest 0
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] pot_x_level, [1] pot_y_level, [2] busy_res
   // configuration
   input  logic                            csr_we,
   input  logic [pptu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pptu_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int DW = pptu_pkg::DELAY_W;
   localparam int CW = pptu_pkg::COUNT_W;

   // ---------------------------------------------------------------- registers
   logic [CW-1:0] discharge_ff;
   logic [DW-1:0] min_delay_ff;
   logic [DW-1:0] max_delay_ff;

   logic                x_leads_ff,  x_leads_in;
   logic [DW-1:0]       x_delay_ff,  x_delay_in;
   logic [DW-1:0]       y_delay_ff,  y_delay_in;
   pptu_pkg::phase_type phase_ff,    phase_in;
   logic [CW-1:0]       count_ff,    count_in;
   logic                lat_lead_ff, lat_lead_in;
   logic [DW-1:0]       lat_first_ff,  lat_first_in;
   logic [DW-1:0]       lat_second_ff, lat_second_in;
   logic [1:0]          levels_ff,   levels_in;   // bit 0 x line, bit 1 y line

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_data_ff,  rsp_data_in;

   logic accept;

   // ---------------------------------------------------------------- helpers
   // Raw delay of one reading: (range - r) / 4, or 0 when r is above the range.
   function automatic logic [pptu_pkg::RAW_W-1:0] raw_delay(
      input logic [pptu_pkg::SAMPLE_W-1:0] v
   );
      logic [pptu_pkg::DIFF_W-1:0] diff;
      diff = pptu_pkg::DIFF_W'(pptu_pkg::SAMPLE_RANGE) - pptu_pkg::DIFF_W'(v);
      if (diff[pptu_pkg::DIFF_W-1]) begin
         return '0;
      end
      return diff[pptu_pkg::RANGE_W-1:2];
   endfunction

   // Above max wins over below min, also when min > max.
   function automatic logic [DW-1:0] clamp_delay(
      input logic [pptu_pkg::RAW_W-1:0] d,
      input logic [DW-1:0]              lo,
      input logic [DW-1:0]              hi
   );
      logic [pptu_pkg::CMP_W-1:0] dd;
      dd = pptu_pkg::CMP_W'(d);
      if (dd > pptu_pkg::CMP_W'(hi)) begin
         return hi;
      end
      if (dd < pptu_pkg::CMP_W'(lo)) begin
         return lo;
      end
      return dd[DW-1:0];
   endfunction

   // ---------------------------------------------------------------- sample path
   logic [pptu_pkg::RAW_W-1:0] raw_x, raw_y, diff_x, diff_y;
   logic                       x_first;

   assign raw_x   = raw_delay(req_tdata[9:0]);
   assign raw_y   = raw_delay(req_tdata[19:10]);
   assign x_first = raw_x < raw_y;                  // tie: y leads
   assign diff_x  = x_first ? raw_x : raw_x - raw_y;
   assign diff_y  = x_first ? raw_y - raw_x : raw_y;

   // ---------------------------------------------------------------- handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------- next state
   // A tick may walk through discharge end, lead edge and trail edge in one go
   // when the latched delays are zero, so the phase checks run in order.
   always_comb begin
      x_leads_in    = x_leads_ff;
      x_delay_in    = x_delay_ff;
      y_delay_in    = y_delay_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      lat_lead_in   = lat_lead_ff;
      lat_first_in  = lat_first_ff;
      lat_second_in = lat_second_ff;
      levels_in     = levels_ff;

      case (req_tuser)
         pptu_pkg::REQ_SAMPLE: begin
            x_leads_in = x_first;
            x_delay_in = clamp_delay(diff_x, min_delay_ff, max_delay_ff);
            y_delay_in = clamp_delay(diff_y, min_delay_ff, max_delay_ff);
         end
         pptu_pkg::REQ_SYNC: begin
            // ignored while a sequence runs
            if (phase_ff == pptu_pkg::PH_IDLE) begin
               levels_in = 2'b11;
               phase_in  = pptu_pkg::PH_DISCH;
               count_in  = '0;
            end
         end
         pptu_pkg::REQ_TICK: begin
            if (phase_ff != pptu_pkg::PH_IDLE) begin
               if (count_ff != pptu_pkg::COUNT_MAX) begin
                  count_in = count_ff + CW'(1);
               end
               if (phase_in == pptu_pkg::PH_DISCH && count_in >= discharge_ff) begin
                  lat_lead_in   = x_leads_ff;
                  lat_first_in  = x_leads_ff ? x_delay_ff : y_delay_ff;
                  lat_second_in = x_leads_ff ? y_delay_ff : x_delay_ff;
                  phase_in      = pptu_pkg::PH_LEAD;
                  count_in      = '0;
               end
               if (phase_in == pptu_pkg::PH_LEAD && count_in >= CW'(lat_first_in)) begin
                  levels_in = levels_in & (lat_lead_in ? 2'b10 : 2'b01);
                  phase_in  = pptu_pkg::PH_TRAIL;
                  count_in  = '0;
               end
               if (phase_in == pptu_pkg::PH_TRAIL && count_in >= CW'(lat_second_in)) begin
                  levels_in = 2'b00;
                  phase_in  = pptu_pkg::PH_IDLE;
                  count_in  = '0;
               end
            end
         end
         default: begin
            // unused code: state unchanged, result shows the current state
         end
      endcase
   end

   // result register: loads on accept, empties when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {phase_in != pptu_pkg::PH_IDLE, levels_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         discharge_ff <= pptu_pkg::DISCHARGE_RST;
         min_delay_ff <= pptu_pkg::MIN_DELAY_RST;
         max_delay_ff <= pptu_pkg::MAX_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            pptu_pkg::CSR_DISCHARGE: discharge_ff <= csr_wdata[CW-1:0];
            pptu_pkg::CSR_MIN_DELAY: min_delay_ff <= csr_wdata[DW-1:0];
            pptu_pkg::CSR_MAX_DELAY: max_delay_ff <= csr_wdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_leads_ff    <= 1'b1;
         x_delay_ff    <= pptu_pkg::MAX_DELAY_RST;
         y_delay_ff    <= pptu_pkg::MAX_DELAY_RST;
         phase_ff      <= pptu_pkg::PH_IDLE;
         count_ff      <= '0;
         lat_lead_ff   <= 1'b1;
         lat_first_ff  <= '0;
         lat_second_ff <= '0;
         levels_ff     <= 2'b00;
      end else if (accept) begin
         x_leads_ff    <= x_leads_in;
         x_delay_ff    <= x_delay_in;
         y_delay_ff    <= y_delay_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         lat_lead_ff   <= lat_lead_in;
         lat_first_ff  <= lat_first_in;
         lat_second_ff <= lat_second_in;
         levels_ff     <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

/* bench/paddle_pot_pulse_timer_unit_tb.sv */
// Self-checking bench for paddle_pot_pulse_timer_unit: a directed table, then random
// sample/sync/tick streams under several register settings, checked item by item.
// Depends on pptu_pkg and paddle_pot_pulse_timer_unit.
module paddle_pot_pulse_timer_unit_tb;

   // tuser code with no meaning; the block must leave its state alone
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Longest quiet stretch in a correct run is the receiver's long hold plus
   // one stall, one sender gap and a register pause.
   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 300;   // receiver back-pressure stretch
   localparam int HOLD_AFTER   = 600;   // results seen before the hold starts
   localparam int DRAIN_CYCLES = 4;     // result shows in the cycle after its item

   // Result fields, x in the lowest bit as on rsp_tdata
   typedef struct packed {
      logic busy;
      logic pot_y;
      logic pot_x;
   } pot_result_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [1:0]                    kind;
      logic [pptu_pkg::SAMPLE_W-1:0] brake;
      logic [pptu_pkg::SAMPLE_W-1:0] throttle;
      logic                          typed;
      pot_result_type                want;
   } stim_row_type;

   // Register setting and item budget of one random phase
   typedef struct packed {
      logic [pptu_pkg::COUNT_W-1:0] discharge;
      logic [pptu_pkg::DELAY_W-1:0] lo;
      logic [pptu_pkg::DELAY_W-1:0] hi;
      logic [10:0]                  budget;
   } phase_plan_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata = '0;
   logic [1:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;
   logic                           csr_we = 1'b0;
   logic [pptu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pptu_pkg::CSR_W-1:0]     csr_wdata = '0;

   // Pot model state: register copies, stored delays, running sequence
   logic [pptu_pkg::COUNT_W-1:0] cfg_discharge;
   logic [pptu_pkg::DELAY_W-1:0] cfg_min;
   logic [pptu_pkg::DELAY_W-1:0] cfg_max;
   logic                         x_ahead;
   logic [pptu_pkg::DELAY_W-1:0] stored_x;
   logic [pptu_pkg::DELAY_W-1:0] stored_y;
   pptu_pkg::phase_type          pot_phase;
   logic [pptu_pkg::COUNT_W-1:0] tick_cnt;
   logic                         run_x_ahead;
   logic [pptu_pkg::DELAY_W-1:0] run_first;
   logic [pptu_pkg::DELAY_W-1:0] run_second;
   logic [1:0]                   line_drive;   // bit 0 x line, bit 1 y line

   pot_result_type expected_levels[$];

   bit snd_burst = 1'b0;
   bit rcv_burst = 1'b0;
   bit hold_done = 1'b0;
   bit run_done  = 1'b0;
   int errors = 0;
   int results_seen = 0;
   int items_sent = 0;
   int working_items = 0;     // items that can change state
   int sequences_done = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   // Directed table, walked with discharge 1, clamp window 0..4.
   // Expected values are typed only where the state is obvious.
   stim_row_type directed_rows [20] = '{
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b1, 3'b000},  // tick while idle
      '{REQ_UNUSED,           10'd1023, 10'd1023, 1'b1, 3'b000},  // unused code
      '{pptu_pkg::REQ_SAMPLE, 10'd1023, 10'd0,    1'b1, 3'b000},  // x leads at 0, y max
      '{pptu_pkg::REQ_SYNC,   10'd0,    10'd0,    1'b1, 3'b111},  // both lines up, busy
      '{pptu_pkg::REQ_SYNC,   10'd1023, 10'd1023, 1'b1, 3'b111},  // sync while busy
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},  // zero lead drops
      '{pptu_pkg::REQ_SAMPLE, 10'd0,    10'd0,    1'b0, 3'b000},  // equal, while busy
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},  // trailing line drops
      '{pptu_pkg::REQ_SYNC,   10'd0,    10'd0,    1'b0, 3'b000},  // runs the equal sample
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},  // y leads, x diff 0
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},
      '{pptu_pkg::REQ_TICK,   10'd0,    10'd0,    1'b0, 3'b000},  // both edges, one tick
      '{pptu_pkg::REQ_SAMPLE, 10'd0,    10'd1023, 1'b0, 3'b000},  // y leads, x max
      '{pptu_pkg::REQ_SAMPLE, 10'd512,  10'd256,  1'b0, 3'b000},
      '{REQ_UNUSED,           10'd0,    10'd0,    1'b1, 3'b000}   // idle again
   };

   // Random phases: zero and full discharge, reset values, inverted window
   phase_plan_type phase_plan [7] = '{
      '{10'd0,    8'd0,   8'd255, 11'd230},
      '{10'd3,    8'd5,   8'd12,  11'd230},
      '{10'd220,  8'd3,   8'd243, 11'd230},
      '{10'd1023, 8'd255, 8'd255, 11'd150},  // discharge outlives the phase
      '{10'd2,    8'd20,  8'd6,   11'd230},  // min above max
      '{10'd1,    8'd0,   8'd0,   11'd230},  // every delay zero
      '{10'd7,    8'd1,   8'd30,  11'd230}
   };

   paddle_pot_pulse_timer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- pot model

   // (range - reading) / 4, floored at 0 for readings above range
   function automatic int unsigned reading_delay(logic [pptu_pkg::SAMPLE_W-1:0] v);
      int d;
      d = pptu_pkg::SAMPLE_RANGE - int'(v);
      if (d < 0)
         d = 0;
      return d / 4;
   endfunction

   // max is checked first, so an inverted window yields max
   function automatic logic [pptu_pkg::DELAY_W-1:0] clamp_to_window(int unsigned d);
      if (d > cfg_max)
         return cfg_max;
      if (d < cfg_min)
         return cfg_min;
      return pptu_pkg::DELAY_W'(d);
   endfunction

   // Advance the model by one item and return the line levels after it
   function automatic pot_result_type step_pots(logic [1:0] kind,
                                                logic [pptu_pkg::SAMPLE_W-1:0] brake,
                                                logic [pptu_pkg::SAMPLE_W-1:0] throttle);
      int unsigned dx;
      int unsigned dy;
      pot_result_type r;
      case (kind)
         pptu_pkg::REQ_SAMPLE: begin
            // shorter delay leads, the other keeps only the difference;
            // a tie hands the lead to y
            dx = reading_delay(brake);
            dy = reading_delay(throttle);
            if (dx < dy) begin
               x_ahead = 1'b1;
               dy -= dx;
            end else begin
               x_ahead = 1'b0;
               dx -= dy;
            end
            stored_x = clamp_to_window(dx);
            stored_y = clamp_to_window(dy);
         end
         pptu_pkg::REQ_SYNC: begin
            if (pot_phase == pptu_pkg::PH_IDLE) begin
               line_drive = 2'b11;
               pot_phase  = pptu_pkg::PH_DISCH;
               tick_cnt   = '0;
            end
         end
         pptu_pkg::REQ_TICK: begin
            if (pot_phase != pptu_pkg::PH_IDLE) begin
               if (tick_cnt < pptu_pkg::COUNT_MAX)
                  tick_cnt++;
               // discharge length is read live; delays latch as it ends
               if (pot_phase == pptu_pkg::PH_DISCH && tick_cnt >= cfg_discharge) begin
                  run_x_ahead = x_ahead;
                  run_first   = x_ahead ? stored_x : stored_y;
                  run_second  = x_ahead ? stored_y : stored_x;
                  pot_phase   = pptu_pkg::PH_LEAD;
                  tick_cnt    = '0;
               end
               // zero delays fall through to the next phase in the same tick
               if (pot_phase == pptu_pkg::PH_LEAD && tick_cnt >= run_first) begin
                  line_drive &= run_x_ahead ? 2'b10 : 2'b01;
                  pot_phase   = pptu_pkg::PH_TRAIL;
                  tick_cnt    = '0;
               end
               if (pot_phase == pptu_pkg::PH_TRAIL && tick_cnt >= run_second) begin
                  line_drive = 2'b00;
                  pot_phase  = pptu_pkg::PH_IDLE;
                  tick_cnt   = '0;
                  sequences_done++;
               end
            end
         end
         default: ;
      endcase
      r.pot_x = line_drive[0];
      r.pot_y = line_drive[1];
      r.busy  = (pot_phase != pptu_pkg::PH_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------- sender

   // Offer one item after a random gap, wait for acceptance, then predict it.
   // With no gap, valid simply stays high from the previous item.
   task automatic send_item(logic [1:0] kind, logic [pptu_pkg::SAMPLE_W-1:0] brake,
                            logic [pptu_pkg::SAMPLE_W-1:0] throttle, logic typed,
                            pot_result_type want);
      int gap;
      pot_result_type predicted;
      gap = snd_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, throttle, brake};
      do @(posedge clock); while (!req_tready);
      if (kind == pptu_pkg::REQ_SAMPLE ||
          (kind == pptu_pkg::REQ_SYNC && pot_phase == pptu_pkg::PH_IDLE) ||
          (kind == pptu_pkg::REQ_TICK && pot_phase != pptu_pkg::PH_IDLE))
         working_items++;
      predicted = step_pots(kind, brake, throttle);
      expected_levels.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Write all three registers once the block has drained
   task automatic configure(logic [pptu_pkg::COUNT_W-1:0] discharge,
                            logic [pptu_pkg::DELAY_W-1:0] lo,
                            logic [pptu_pkg::DELAY_W-1:0] hi);
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= pptu_pkg::CSR_DISCHARGE;
      csr_wdata <= discharge;
      @(posedge clock);
      cfg_discharge = discharge;
      csr_index <= pptu_pkg::CSR_MIN_DELAY;
      csr_wdata <= pptu_pkg::CSR_W'(lo);
      @(posedge clock);
      cfg_min = lo;
      csr_index <= pptu_pkg::CSR_MAX_DELAY;
      csr_wdata <= pptu_pkg::CSR_W'(hi);
      @(posedge clock);
      cfg_max = hi;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Half the readings sit near full scale so delays stay short
   function automatic logic [pptu_pkg::SAMPLE_W-1:0] rand_reading();
      if ($urandom_range(0, 1) == 1)
         return pptu_pkg::SAMPLE_W'($urandom_range(0, 1023));
      return pptu_pkg::SAMPLE_W'(1023 - $urandom_range(0, 60));
   endfunction

   // Mostly full sequences (sample, sync, ticks until idle) with samples,
   // stray syncs and unused codes mixed in; the rest is random noise.
   // The budget counts every item sent.
   task automatic run_phase(int budget);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(0, 3) != 0) begin
            send_item(pptu_pkg::REQ_SAMPLE, rand_reading(), rand_reading(), 1'b0, '0);
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3))
                  send_item(pptu_pkg::REQ_TICK, rand_reading(), rand_reading(),
                            1'b0, '0);
            end
            send_item(pptu_pkg::REQ_SYNC, rand_reading(), rand_reading(), 1'b0, '0);
            while (pot_phase != pptu_pkg::PH_IDLE && items_sent - start < budget) begin
               pick = $urandom_range(0, 19);
               case (pick)
                  0: send_item(pptu_pkg::REQ_SAMPLE, rand_reading(), rand_reading(),
                               1'b0, '0);
                  1: send_item(pptu_pkg::REQ_SYNC, rand_reading(), rand_reading(),
                               1'b0, '0);
                  2: send_item(REQ_UNUSED, rand_reading(), rand_reading(), 1'b0, '0);
                  default: send_item(pptu_pkg::REQ_TICK, rand_reading(), rand_reading(),
                                     1'b0, '0);
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 5))
               send_item(2'($urandom_range(0, 3)),
                         pptu_pkg::SAMPLE_W'($urandom_range(0, 1023)),
                         pptu_pkg::SAMPLE_W'($urandom_range(0, 1023)), 1'b0, '0);
         end
      end
   endtask

   // ---------------------------------------------------------------- main flow

   initial begin : stimulus
      int i;
      cfg_discharge = pptu_pkg::DISCHARGE_RST;
      cfg_min       = pptu_pkg::MIN_DELAY_RST;
      cfg_max       = pptu_pkg::MAX_DELAY_RST;
      x_ahead       = 1'b1;
      stored_x      = 8'd243;   // stored delays come out of reset at 243
      stored_y      = 8'd243;
      pot_phase     = pptu_pkg::PH_IDLE;
      tick_cnt      = '0;
      run_x_ahead   = 1'b1;
      run_first     = '0;
      run_second    = '0;
      line_drive    = 2'b00;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(10'd1, 8'd0, 8'd4);
      for (i = 0; i < $size(directed_rows); i++)
         send_item(directed_rows[i].kind, directed_rows[i].brake, directed_rows[i].throttle,
                   directed_rows[i].typed, directed_rows[i].want);

      // vary who idles: some phases run a side back to back, one runs both
      for (i = 0; i < $size(phase_plan); i++) begin
         snd_burst = (i % 3 == 1) || (i == 6);
         rcv_burst = (i % 3 == 2) || (i == 6);
         configure(phase_plan[i].discharge, phase_plan[i].lo, phase_plan[i].hi);
         run_phase(int'(phase_plan[i].budget));
      end

      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done = 1'b1;

      $display("Run covered %0d items (%0d able to change state) under %0d register settings.",
               items_sent, working_items, settings_used);
      $display("%0d pot sequences ran to completion; %0d results checked, %0d mismatches.",
               sequences_done, results_seen, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin : result_sink
      int stall;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         // one long hold: the result register fills, req_tready drops and the
         // sender keeps offering its item
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         stall = rcv_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      pot_result_type want;
      pot_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = pot_result_type'(rsp_tdata[2:0]);
         results_seen++;
         if (expected_levels.size() == 0) begin
            $error("result %b arrived with nothing expected", rsp_tdata);
            errors++;
         end else begin
            want = expected_levels.pop_front();
            if (got.pot_x !== want.pot_x) begin
               $error("pot_x_level: expected %0d, got %0d", want.pot_x, got.pot_x);
               errors++;
            end
            if (got.pot_y !== want.pot_y) begin
               $error("pot_y_level: expected %0d, got %0d", want.pot_y, got.pot_y);
               errors++;
            end
            if (got.busy !== want.busy) begin
               $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || run_done || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
